// ===== design/ipc_pkg.sv =====
// Shared types and constants for the interval partition counter.
`timescale 1ns / 1ps
package ipc_pkg;

  localparam int TIME_W = 32;
  localparam int EXTRA_W = 10;
  localparam logic [EXTRA_W-1:0] EXTRA_MAX = 10'd1023;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SORT_OUTER,
    OP_SORT_KEY,
    OP_SORT_RD,
    OP_SORT_CMP,
    OP_SW_RD,
    OP_SW_DEC,
    OP_PU_CHK,
    OP_PU_CMP,
    OP_RP_L,
    OP_RP_R,
    OP_RP_CMP,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } ipc_cmd_t;

  typedef struct packed {
    logic sort_done;
    logic sj_zero;
    logic key_gt;
    logic sw_done;
    logic reuse;
    logic pu_root;
    logic pu_stop;
    logic rp_leaf;
    logic rp_stop;
  } ipc_sts_t;

endpackage

// ===== design/ipc_ctrl.sv =====
// Sequencing state machine for the interval partition counter.
`timescale 1ns / 1ps
module ipc_ctrl import ipc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ipc_sts_t sts,
  output ipc_cmd_t cmd
);

  typedef enum logic [12:0] {
    S_LOAD       = 13'b0000000000001,
    S_SORT_OUTER = 13'b0000000000010,
    S_SORT_KEY   = 13'b0000000000100,
    S_SORT_RD    = 13'b0000000001000,
    S_SORT_CMP   = 13'b0000000010000,
    S_SW_RD      = 13'b0000000100000,
    S_SW_DEC     = 13'b0000001000000,
    S_PU_CHK     = 13'b0000010000000,
    S_PU_CMP     = 13'b0000100000000,
    S_RP_L       = 13'b0001000000000,
    S_RP_R       = 13'b0010000000000,
    S_RP_CMP     = 13'b0100000000000,
    S_DONE       = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state_r == S_LOAD);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = accept;
    cmd.op     = OP_NONE;
    unique case (state_r)
      S_LOAD: begin
        cmd.op = OP_LOAD;
        if (accept && in_last) state_nxt = S_SORT_OUTER;
      end
      S_SORT_OUTER: begin
        cmd.op    = OP_SORT_OUTER;
        state_nxt = sts.sort_done ? S_SW_RD : S_SORT_KEY;
      end
      S_SORT_KEY: begin
        cmd.op    = OP_SORT_KEY;
        state_nxt = S_SORT_RD;
      end
      S_SORT_RD: begin
        cmd.op    = OP_SORT_RD;
        state_nxt = sts.sj_zero ? S_SORT_OUTER : S_SORT_CMP;
      end
      S_SORT_CMP: begin
        cmd.op    = OP_SORT_CMP;
        state_nxt = sts.key_gt ? S_SORT_RD : S_SORT_OUTER;
      end
      S_SW_RD: begin
        cmd.op    = OP_SW_RD;
        state_nxt = sts.sw_done ? S_DONE : S_SW_DEC;
      end
      S_SW_DEC: begin
        cmd.op    = OP_SW_DEC;
        state_nxt = sts.reuse ? S_RP_L : S_PU_CHK;
      end
      S_PU_CHK: begin
        cmd.op    = OP_PU_CHK;
        state_nxt = sts.pu_root ? S_SW_RD : S_PU_CMP;
      end
      S_PU_CMP: begin
        cmd.op    = OP_PU_CMP;
        state_nxt = sts.pu_stop ? S_SW_RD : S_PU_CHK;
      end
      S_RP_L: begin
        cmd.op    = OP_RP_L;
        state_nxt = sts.rp_leaf ? S_SW_RD : S_RP_R;
      end
      S_RP_R: begin
        cmd.op    = OP_RP_R;
        state_nxt = S_RP_CMP;
      end
      S_RP_CMP: begin
        cmd.op    = OP_RP_CMP;
        state_nxt = sts.rp_stop ? S_SW_RD : S_RP_L;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.op    = OP_DONE;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == OP_DONE) out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/ipc_dp.sv =====
// Datapath of the interval partition counter: interval store, heap and counters.
`timescale 1ns / 1ps
module ipc_dp import ipc_pkg::*; #(
  parameter int MAX_INTERVALS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ipc_cmd_t           cmd,
  output ipc_sts_t           sts,
  input  logic [TIME_W-1:0]  in_start_time,
  input  logic [TIME_W-1:0]  in_end_time,
  input  logic               in_last,
  output logic [EXTRA_W-1:0] out_extra_resources,
  output logic               out_overflow
);

  localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);
  localparam logic [TIME_W-1:0] SIGN_BIAS = {1'b1, {(TIME_W-1){1'b0}}};

  logic [2*TIME_W-1:0] store_mem [MAX_INTERVALS];
  logic [TIME_W-1:0]   heap_mem  [MAX_INTERVALS];

  logic [2*TIME_W-1:0] store_rd_r;
  logic [TIME_W-1:0]   heap_rd_r;

  logic [CW-1:0]      load_cnt_r, load_cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CW-1:0]      si_r, si_nxt;
  logic [CW-1:0]      sj_r, sj_nxt;
  logic [2*TIME_W-1:0] key_r, key_nxt;
  logic [CW-1:0]      wi_r, wi_nxt;
  logic [CW-1:0]      hsize_r, hsize_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic [TIME_W-1:0]  hv_r, hv_nxt;
  logic [TIME_W-1:0]  hl_r, hl_nxt;
  logic [TIME_W-1:0]  top_r, top_nxt;
  logic [EXTRA_W-1:0] extra_r, extra_nxt;
  logic [EXTRA_W-1:0] out_extra_r, out_extra_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               s_we;
  logic [IW-1:0]      s_wa, s_ra;
  logic [2*TIME_W-1:0] s_wd;
  logic               h_we;
  logic [IW-1:0]      h_wa, h_ra;
  logic [TIME_W-1:0]  h_wd;

  logic [CW-1:0]      parent;
  logic [CW:0]        lchild, rchild;
  logic               r_ok, take_r;
  logic [TIME_W-1:0]  mval;
  logic [CW-1:0]      midx;
  logic [TIME_W-1:0]  sw_start;

  assign parent   = (hi_r - 1'b1) >> 1;
  assign lchild   = {hi_r, 1'b1};
  assign rchild   = lchild + 1'b1;
  assign r_ok     = rchild < {1'b0, hsize_r};
  assign take_r   = r_ok && (heap_rd_r < hl_r);
  assign mval     = take_r ? heap_rd_r : hl_r;
  assign midx     = take_r ? rchild[CW-1:0] : lchild[CW-1:0];
  assign sw_start = store_rd_r[2*TIME_W-1:TIME_W];

  assign sts.sort_done = si_r >= load_cnt_r;
  assign sts.sj_zero   = sj_r == '0;
  assign sts.key_gt    = store_rd_r > key_r;
  assign sts.sw_done   = wi_r >= load_cnt_r;
  assign sts.reuse     = (wi_r != '0) && (hsize_r != '0) && (top_r <= sw_start);
  assign sts.pu_root   = hi_r == '0;
  assign sts.pu_stop   = heap_rd_r <= hv_r;
  assign sts.rp_leaf   = lchild >= {1'b0, hsize_r};
  assign sts.rp_stop   = hv_r <= mval;

  always_comb begin
    load_cnt_nxt  = load_cnt_r;
    ovf_nxt       = ovf_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    key_nxt       = key_r;
    wi_nxt        = wi_r;
    hsize_nxt     = hsize_r;
    hi_nxt        = hi_r;
    hv_nxt        = hv_r;
    hl_nxt        = hl_r;
    extra_nxt     = extra_r;
    out_extra_nxt = out_extra_r;
    out_ovf_nxt   = out_ovf_r;
    s_we = 1'b0;
    s_wa = load_cnt_r[IW-1:0];
    s_wd = {in_start_time ^ SIGN_BIAS, in_end_time ^ SIGN_BIAS};
    s_ra = si_r[IW-1:0];
    h_we = 1'b0;
    h_wa = hi_r[IW-1:0];
    h_wd = hv_r;
    h_ra = parent[IW-1:0];
    unique case (cmd.op)
      OP_LOAD: begin
        if (cmd.accept) begin
          if (load_cnt_r < MAX_CNT) begin
            s_we         = 1'b1;
            load_cnt_nxt = load_cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) si_nxt = CW'(1);
        end
      end
      OP_SORT_OUTER: begin
        s_ra = si_r[IW-1:0];
        if (sts.sort_done) begin
          wi_nxt    = '0;
          hsize_nxt = '0;
          extra_nxt = '0;
        end
      end
      OP_SORT_KEY: begin
        key_nxt = store_rd_r;
        sj_nxt  = si_r;
      end
      OP_SORT_RD: begin
        s_ra = IW'(sj_r - 1'b1);
        if (sts.sj_zero) begin
          s_we   = 1'b1;
          s_wa   = '0;
          s_wd   = key_r;
          si_nxt = si_r + 1'b1;
        end
      end
      OP_SORT_CMP: begin
        s_we = 1'b1;
        s_wa = sj_r[IW-1:0];
        if (sts.key_gt) begin
          s_wd   = store_rd_r;
          sj_nxt = sj_r - 1'b1;
        end else begin
          s_wd   = key_r;
          si_nxt = si_r + 1'b1;
        end
      end
      OP_SW_RD: begin
        s_ra = wi_r[IW-1:0];
      end
      OP_SW_DEC: begin
        hv_nxt = store_rd_r[TIME_W-1:0];
        wi_nxt = wi_r + 1'b1;
        if (sts.reuse) begin
          hi_nxt = '0;
        end else begin
          if ((wi_r != '0) && (extra_r != EXTRA_MAX)) extra_nxt = extra_r + 1'b1;
          hi_nxt    = hsize_r;
          hsize_nxt = hsize_r + 1'b1;
        end
      end
      OP_PU_CHK: begin
        h_ra = parent[IW-1:0];
        if (sts.pu_root) h_we = 1'b1;
      end
      OP_PU_CMP: begin
        h_we = 1'b1;
        if (!sts.pu_stop) begin
          h_wd   = heap_rd_r;
          hi_nxt = parent;
        end
      end
      OP_RP_L: begin
        h_ra = lchild[IW-1:0];
        if (sts.rp_leaf) h_we = 1'b1;
      end
      OP_RP_R: begin
        hl_nxt = heap_rd_r;
        h_ra   = rchild[IW-1:0];
      end
      OP_RP_CMP: begin
        h_we = 1'b1;
        if (!sts.rp_stop) begin
          h_wd   = mval;
          hi_nxt = midx;
        end
      end
      OP_DONE: begin
        out_extra_nxt = extra_r;
        out_ovf_nxt   = ovf_r;
        load_cnt_nxt  = '0;
        ovf_nxt       = 1'b0;
        hsize_nxt     = '0;
      end
      default: ;
    endcase
  end

  assign top_nxt = (h_we && (h_wa == '0)) ? h_wd : top_r;

  always_ff @(posedge clk) begin
    if (s_we) store_mem[s_wa] <= s_wd;
    store_rd_r <= store_mem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_wa] <= h_wd;
    heap_rd_r <= heap_mem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      ovf_r      <= 1'b0;
      hsize_r    <= '0;
      extra_r    <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
      ovf_r      <= ovf_nxt;
      hsize_r    <= hsize_nxt;
      extra_r    <= extra_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r        <= si_nxt;
    sj_r        <= sj_nxt;
    key_r       <= key_nxt;
    wi_r        <= wi_nxt;
    hi_r        <= hi_nxt;
    hv_r        <= hv_nxt;
    hl_r        <= hl_nxt;
    top_r       <= top_nxt;
    out_extra_r <= out_extra_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_extra_resources = out_extra_r;
  assign out_overflow        = out_ovf_r;

endmodule

// ===== design/interval_partition_counter.sv =====
// Top level of the interval partition counter.
//
// Intervals enter on the in_ channel, one item per cycle while loading; in_last
// closes a set. The stored intervals are then sorted by start and end time with
// an insertion sort over the interval memory, and swept with a min-heap of end
// times held in a second memory. One result item on the out_ channel carries
// the number of resources needed beyond the first and the overflow flag.
// After the last item, the sort shifts one position at a time and the sweep
// climbs the heap one level at a time on a push or descends it on a replace;
// each memory has a single read port, which sets this pace. in_ready is low
// from the last item until the result is registered.
// A result waiting on a stalled receiver does not block loading of the next set.
// Reset empties the set, clears the load count, overflow flag, heap size and
// extra count and drops any pending result; the memories need no clearing.
`timescale 1ns / 1ps
module interval_partition_counter import ipc_pkg::*; #(
  parameter int MAX_INTERVALS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TIME_W-1:0]  in_start_time,
  input  logic [TIME_W-1:0]  in_end_time,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [EXTRA_W-1:0] out_extra_resources,
  output logic               out_overflow
);

  ipc_cmd_t cmd;
  ipc_sts_t sts;

  ipc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ipc_dp #(.MAX_INTERVALS(MAX_INTERVALS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_start_time       (in_start_time),
    .in_end_time         (in_end_time),
    .in_last             (in_last),
    .out_extra_resources (out_extra_resources),
    .out_overflow        (out_overflow)
  );

  a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still open after the last item of a set");

  a_result_reopens_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result issued without returning to loading");

  a_sweep_heap_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    u_dp.hsize_r <= u_dp.load_cnt_r)
    else $error("heap larger than the stored set");

endmodule
